@@ rtl/fca_pkg.sv @@
// Shared types and constants for the block link table allocator.
// No dependencies; imported by fat_chain_allocator.
package fca_pkg;

  localparam int LINK_W = 16;

  localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;
  localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;

  typedef logic [2:0] action_t;

  localparam action_t ACT_FORMAT     = 3'd0;
  localparam action_t ACT_ALLOC      = 3'd1;
  localparam action_t ACT_EXTEND     = 3'd2;
  localparam action_t ACT_FREE_CHAIN = 3'd3;
  localparam action_t ACT_FREE_BLOCK = 3'd4;
  localparam action_t ACT_READ_LINK  = 3'd5;

  typedef logic [0:0] reg_idx_t;

  localparam reg_idx_t REG_BLOCKS_IN_USE = 1'd0;
  localparam reg_idx_t REG_RESERVED      = 1'd1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_LONG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_SCAN,
    S_LINK,
    S_RDLINK,
    S_RESP
  } state_e;

endpackage

@@ rtl/fat_chain_allocator.sv @@
// Block link table allocator: format, allocate, extend, free and read chains.
// Depends on fca_pkg. Holds the link table in one single-port-write,
// one-port-read synchronous memory.
//
// Operation: read link and free block touch one entry; allocate scans one entry per
//   cycle (up to n entries); chain walks visit one entry per cycle (up to
//   NUM_BLOCKS), extend adds a scan; format sweeps all NUM_BLOCKS entries.
// One word in flight: the memory read port and the walk/scan loop set the pace.
// Reset: a clearing pass writes every entry free;
//   s_axis_tready stays low until it ends. Config writes are taken at any time.
module fat_chain_allocator
  import fca_pkg::*;
#(
  parameter int NUM_BLOCKS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  reg_idx_t    cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] action, [11:3] block, [15:12] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [8:0] result_block, [9] is_end, [11:10] status
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = AW + 1;
  localparam int XW = LINK_W + 1;   // compare width for links and counts

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [9:0]        bu_q;
  logic [6:0]        rb_q;
  logic [CW-1:0]     idx_q, idx_d;        // clear sweep / scan issue index
  logic              fmt_q, fmt_d;        // sweep is a format, not reset
  logic              pv_q, pv_d;          // scan: a read is in flight
  logic              m_tvalid_q, m_tvalid_d;
  logic              fwd_q, fwd_d;
  action_t           act_q, act_d;
  logic [AW-1:0]     cur_q, cur_d;        // walk position, tail after walk
  logic [AW-1:0]     steps_q, steps_d;
  logic [AW-1:0]     pidx_q, pidx_d;      // scan: address of data in flight
  logic [8:0]        res_blk_q, res_blk_d;
  logic              res_end_q, res_end_d;
  status_e           res_stat_q, res_stat_d;
  logic [15:0]       m_tdata_q, m_tdata_d;
  logic [LINK_W-1:0] fwd_data_q;

  // link table
  logic [LINK_W-1:0] mem_q [NUM_BLOCKS];
  logic [LINK_W-1:0] mem_rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [LINK_W-1:0] mem_wd;
  logic [AW-1:0]     rd_addr;

  // ------------------------------------------------------------------
  // Shared conditions
  // ------------------------------------------------------------------
  action_t           in_action;
  logic [8:0]        in_block;
  logic [XW-1:0]     blk_x;
  logic [XW-1:0]     n_x;
  logic [LINK_W-1:0] rdata;
  logic [LINK_W-1:0] pidx_x;
  logic              accept, out_free, blk_ok;
  logic              v_end, v_ok, walk_last, scan_hit, scan_more, clr_last;
  logic              free_mode;

  assign in_action = s_axis_tdata[2:0];
  assign in_block  = s_axis_tdata[11:3];
  assign blk_x     = XW'(in_block);

  // effective block count: min(blocks_in_use, NUM_BLOCKS)
  assign n_x = (XW'(bu_q) < XW'(NUM_BLOCKS)) ? XW'(bu_q) : XW'(NUM_BLOCKS);

  // read data, with a write to the same entry in the read cycle forwarded
  assign rdata  = fwd_q ? fwd_data_q : mem_rd_q;
  assign pidx_x = LINK_W'(pidx_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign blk_ok        = blk_x < n_x;

  assign v_end     = (rdata == LINK_END);
  assign v_ok      = (rdata != LINK_FREE) && (XW'(rdata) < n_x);
  assign walk_last = (steps_q == AW'(NUM_BLOCKS - 1));
  assign scan_hit  = pv_q && (rdata == LINK_FREE);
  assign scan_more = XW'(idx_q) < n_x;
  assign clr_last  = (idx_q[AW-1:0] == AW'(NUM_BLOCKS - 1));
  assign free_mode = (act_q == ACT_FREE_CHAIN);

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = fmt_q ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_action) inside
            ACT_FORMAT:                 state_d = S_CLEAR;
            ACT_ALLOC:                  state_d = (n_x == '0) ? S_RESP : S_SCAN;
            ACT_EXTEND, ACT_FREE_CHAIN: state_d = blk_ok ? S_WALK : S_RESP;
            ACT_READ_LINK:              state_d = blk_ok ? S_RDLINK : S_RESP;
            default:                    state_d = S_RESP;
          endcase
        end
      end
      S_WALK: begin
        if (v_end) state_d = free_mode ? S_RESP : S_SCAN;
        else if (!v_ok || walk_last) state_d = S_RESP;
      end
      S_SCAN: begin
        if (scan_hit) state_d = (act_q == ACT_EXTEND) ? S_LINK : S_RESP;
        else if (!scan_more) state_d = S_RESP;
      end
      S_LINK:   state_d = S_RESP;
      S_RDLINK: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath and memory control
  // ------------------------------------------------------------------
  always_comb begin
    idx_d      = idx_q;
    fmt_d      = fmt_q;
    pv_d       = pv_q;
    act_d      = act_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    pidx_d     = pidx_q;
    res_blk_d  = res_blk_q;
    res_end_d  = res_end_q;
    res_stat_d = res_stat_q;
    m_tdata_d  = m_tdata_q;
    m_tvalid_d = m_tvalid_q;
    mem_we     = 1'b0;
    mem_wa     = cur_q;
    mem_wd     = LINK_FREE;
    rd_addr    = idx_q[AW-1:0];

    // drop the result word once taken
    if (m_tvalid_q && m_axis_tready) m_tvalid_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // reserved leading entries within the block count become end on format, all else free
        mem_we = 1'b1;
        mem_wa = idx_q[AW-1:0];
        if (fmt_q && (XW'(idx_q) < XW'(rb_q)) && (XW'(idx_q) < n_x)) mem_wd = LINK_END;
        idx_d = idx_q + 1'b1;
      end
      S_IDLE: begin
        rd_addr = blk_x[AW-1:0];
        if (accept) begin
          act_d      = in_action;
          res_blk_d  = '0;
          res_end_d  = 1'b0;
          res_stat_d = STAT_OK;
          idx_d      = '0;
          pv_d       = 1'b0;
          cur_d      = blk_x[AW-1:0];
          steps_d    = '0;
          fmt_d      = 1'b1;
          case (in_action) inside
            ACT_ALLOC: begin
              if (n_x == '0) res_stat_d = STAT_FULL;
            end
            ACT_EXTEND, ACT_FREE_CHAIN, ACT_READ_LINK: begin
              if (!blk_ok) res_stat_d = STAT_RANGE;
            end
            ACT_FREE_BLOCK: begin
              if (blk_ok) begin
                mem_we = 1'b1;
                mem_wa = blk_x[AW-1:0];
                mem_wd = LINK_FREE;
              end else begin
                res_stat_d = STAT_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // one entry per cycle: next address comes straight from read data
        steps_d = steps_q + 1'b1;
        if (free_mode) begin
          mem_we = 1'b1;
          mem_wa = cur_q;
          mem_wd = LINK_FREE;
        end
        if (v_end) begin
          idx_d = '0;
          pv_d  = 1'b0;
        end else if (!v_ok) begin
          res_stat_d = STAT_RANGE;
        end else if (walk_last) begin
          res_stat_d = STAT_LONG;
        end else begin
          cur_d   = rdata[AW-1:0];
          rd_addr = rdata[AW-1:0];
        end
      end
      S_SCAN: begin
        // issue one read per cycle, test the entry read the cycle before
        if (scan_hit) begin
          mem_we = 1'b1;
          mem_wa = pidx_q;
          mem_wd = LINK_END;
          if (act_q == ACT_ALLOC) res_blk_d = pidx_x[8:0];
        end else if (scan_more) begin
          rd_addr = idx_q[AW-1:0];
          pv_d    = 1'b1;
          pidx_d  = idx_q[AW-1:0];
          idx_d   = idx_q + 1'b1;
        end else begin
          res_stat_d = STAT_FULL;
        end
      end
      S_LINK: begin
        // hook the new block onto the tail found by the walk
        mem_we    = 1'b1;
        mem_wa    = cur_q;
        mem_wd    = pidx_x;
        res_blk_d = pidx_x[8:0];
      end
      S_RDLINK: begin
        if (v_end) res_end_d = 1'b1;
        else res_blk_d = rdata[8:0];
      end
      S_RESP: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {4'b0000, res_stat_q, res_end_q, res_blk_q};
        end
      end
      default: ;
    endcase
  end

  assign fwd_d = mem_we && (mem_wa == rd_addr);

  // ------------------------------------------------------------------
  // Link table memory
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mem_rd_q <= mem_q[rd_addr];
  end

  // ------------------------------------------------------------------
  // Config registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bu_q <= 10'd500;
      rb_q <= 7'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BLOCKS_IN_USE: bu_q <= cfg_wdata_i;
        REG_RESERVED:      rb_q <= cfg_wdata_i[6:0];
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      fmt_q      <= 1'b0;
      pv_q       <= 1'b0;
      m_tvalid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      fmt_q      <= fmt_d;
      pv_q       <= pv_d;
      m_tvalid_q <= m_tvalid_d;
      fwd_q      <= fwd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    cur_q      <= cur_d;
    steps_q    <= steps_d;
    pidx_q     <= pidx_d;
    res_blk_q  <= res_blk_d;
    res_end_q  <= res_end_d;
    res_stat_q <= res_stat_d;
    m_tdata_q  <= m_tdata_d;
    fwd_data_q <= mem_wd;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

@@ dv/fat_chain_allocator_test.sv @@
// Self-checking testbench for fat_chain_allocator: directed and random command words.
// Holds its own copy of the link table to predict each result word.
// Depends on fca_pkg and the fat_chain_allocator RTL; reads no files.
module fat_chain_allocator_test;
  import fca_pkg::*;

  localparam int NUM_BLK = 512;
  // Slowest legal word is an extend: a full walk plus a full scan. Allow that for
  // every word, plus sender gaps and receiver stalls, several times over.
  localparam int LIMIT_CYCLES = 5_000_000;
  // Every command returns exactly one word, so little settling is needed at the end.
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS = 195;
  localparam int MAX_HEADS = 32;

  // Action codes that the block must ignore; they still return an all-zero word.
  localparam action_t ACT_UNUSED_LO = 3'd6;
  localparam action_t ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [8:0] blk;
    logic       end_flag;
    status_e    st;
  } link_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_addr = REG_BLOCKS_IN_USE;
  logic [9:0]  cfg_wdata = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic [15:0] cmd_word = '0;
  logic        reply_valid;
  logic        reply_ready = 1'b0;
  logic [15:0] reply_word;

  // Predictor state: table copy and the two registers, at their reset values.
  logic [LINK_W-1:0] link_copy [NUM_BLK];
  logic [9:0]        blocks_cfg = 10'd500;
  logic [6:0]        reserved_cfg = 7'd4;

  link_reply_t pending_replies [$];
  logic [8:0]  chain_heads [$];
  int          errors = 0;
  int          cycles = 0;

  // Idle shaping: sender bursts/gaps and receiver ready/stall runs.
  int tx_burst = 0;
  bit tx_steady = 1'b0;
  int rx_run = 0;
  bit rx_stall = 1'b0;
  bit rx_steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fat_chain_allocator #(
    .NUM_BLOCKS(NUM_BLK)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(cmd_valid),
    .s_axis_tready(cmd_ready),
    .s_axis_tdata (cmd_word),    // [2:0] action, [11:3] block, [15:12] zero
    .m_axis_tvalid(reply_valid),
    .m_axis_tready(reply_ready),
    .m_axis_tdata (reply_word)   // [8:0] result_block, [9] is_end, [11:10] status
  );

  // Effective block count: the register value, saturated at the table depth.
  function automatic int active_blocks();
    return (blocks_cfg < NUM_BLK) ? int'(blocks_cfg) : NUM_BLK;
  endfunction

  function automatic int lowest_free(int n);
    for (int i = 0; i < n; i++) begin
      if (link_copy[i] == LINK_FREE) return i;
    end
    return -1;
  endfunction

  // Apply one command to the table copy and return the word the block owes.
  function automatic link_reply_t predict_link_action(action_t act, logic [8:0] blk);
    link_reply_t r;
    int n, cur, got;
    logic [LINK_W-1:0] v;
    bit done;
    n = active_blocks();
    r = '0;
    r.st = STAT_OK;
    case (act)
      ACT_FORMAT: begin
        for (int i = 0; i < NUM_BLK; i++) begin
          link_copy[i] = (i < reserved_cfg && i < n) ? LINK_END : LINK_FREE;
        end
      end
      ACT_ALLOC: begin
        got = lowest_free(n);
        if (got < 0) begin
          r.st = STAT_FULL;
        end else begin
          link_copy[got] = LINK_END;
          r.blk = 9'(got);
        end
      end
      ACT_EXTEND, ACT_FREE_CHAIN: begin
        if (blk >= n) begin
          r.st = STAT_RANGE;
        end else begin
          // Walk to the tail; free chain clears each entry as it goes,
          // including one holding a bad link.
          cur = blk;
          done = 1'b0;
          r.st = STAT_LONG;
          for (int steps = 0; steps < NUM_BLK && !done; steps++) begin
            v = link_copy[cur];
            if (act == ACT_FREE_CHAIN) link_copy[cur] = LINK_FREE;
            if (v == LINK_END) begin
              r.st = STAT_OK;
              done = 1'b1;
            end else if (v == LINK_FREE || v >= n) begin
              r.st = STAT_RANGE;
              done = 1'b1;
            end else begin
              cur = v;
            end
          end
          if (act == ACT_EXTEND && r.st == STAT_OK) begin
            got = lowest_free(n);
            if (got < 0) begin
              r.st = STAT_FULL;
            end else begin
              link_copy[got] = LINK_END;
              link_copy[cur] = LINK_W'(got);
              r.blk = 9'(got);
            end
          end
        end
      end
      ACT_FREE_BLOCK: begin
        if (blk >= n) r.st = STAT_RANGE;
        else link_copy[blk] = LINK_FREE;
      end
      ACT_READ_LINK: begin
        if (blk >= n) r.st = STAT_RANGE;
        else if (link_copy[blk] == LINK_END) r.end_flag = 1'b1;
        else r.blk = link_copy[blk][8:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command word, hold it until taken, then queue its prediction.
  task automatic send_cmd(input action_t act, input logic [8:0] blk,
                          output link_reply_t want);
    int gap;
    if (!tx_steady && tx_burst == 0) begin
      gap = $urandom_range(1, 6);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      tx_burst = $urandom_range(1, 24);
    end
    if (tx_burst > 0) tx_burst--;
    cmd_valid <= 1'b1;
    cmd_word  <= {4'b0000, blk, act};
    do begin
      @(posedge clk);
    end while (!cmd_ready);
    want = predict_link_action(act, blk);
    pending_replies.push_back(want);
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain_replies();
    cmd_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLOCKS_IN_USE) blocks_cfg = val;
    else reserved_cfg = val[6:0];
    @(posedge clk);
  endtask

  // Straight out of the clearing pass: every entry free, block 0 allocatable,
  // which lets a chain link to block 0 (a bad link).
  task automatic test_reset_behavior();
    link_reply_t r;
    send_cmd(ACT_READ_LINK, 9'd0, r);    // free entry reads as zero
    send_cmd(ACT_ALLOC, 9'd0, r);        // takes block 0
    send_cmd(ACT_ALLOC, 9'd0, r);        // takes block 1
    send_cmd(ACT_FREE_BLOCK, 9'd0, r);
    send_cmd(ACT_EXTEND, 9'd1, r);       // reuses block 0: 1 -> 0
    send_cmd(ACT_EXTEND, 9'd1, r);       // link of zero stops the walk
    send_cmd(ACT_FREE_CHAIN, 9'd1, r);   // clears block 1, then bad link
    send_cmd(ACT_READ_LINK, 9'd0, r);    // end marker
    send_cmd(ACT_READ_LINK, 9'd511, r);  // start out of range
    send_cmd(ACT_FREE_BLOCK, 9'd500, r); // first block past the count
    send_cmd(ACT_EXTEND, 9'd499, r);     // start on a free entry
    send_cmd(ACT_UNUSED_LO, 9'h1FF, r);
    send_cmd(ACT_UNUSED_HI, 9'h155, r);
  endtask

  // Register extremes, a full table, and links that fall past a shrunk count.
  task automatic test_table_limits();
    link_reply_t r;
    write_reg(REG_BLOCKS_IN_USE, 10'd8);
    write_reg(REG_RESERVED, 10'd64);
    send_cmd(ACT_FORMAT, 9'd0, r);       // reserved area covers every block in use
    send_cmd(ACT_ALLOC, 9'd0, r);        // no free block
    send_cmd(ACT_EXTEND, 9'd2, r);       // tail found, then no free block
    send_cmd(ACT_READ_LINK, 9'd7, r);
    write_reg(REG_BLOCKS_IN_USE, 10'h3FF); // saturates at the table depth
    write_reg(REG_RESERVED, 10'd1);
    send_cmd(ACT_FORMAT, 9'd0, r);
    send_cmd(ACT_ALLOC, 9'd0, r);        // block 1
    send_cmd(ACT_EXTEND, 9'd1, r);       // 1 -> 2
    send_cmd(ACT_EXTEND, 9'd1, r);       // 2 -> 3
    send_cmd(ACT_READ_LINK, 9'd511, r);  // top entry is in range now
    write_reg(REG_BLOCKS_IN_USE, 10'd3);
    send_cmd(ACT_EXTEND, 9'd1, r);       // link to 3 lies past the count
    send_cmd(ACT_FREE_CHAIN, 9'd1, r);   // clears 1 and 2, then stops
    send_cmd(ACT_READ_LINK, 9'd2, r);
  endtask

  // Mostly well-formed traffic: allocate and extend on known chain heads so the
  // walks get long, with free, read, format and stray codes mixed in.
  task automatic test_random_traffic(input logic [9:0] count, input logic [9:0] rsvd,
                                     input bit steady_tx, input bit steady_rx);
    link_reply_t r;
    action_t act;
    logic [8:0] blk;
    int pick, sel, n;
    write_reg(REG_BLOCKS_IN_USE, count);
    write_reg(REG_RESERVED, rsvd);
    tx_steady = steady_tx;
    rx_steady = steady_rx;
    chain_heads.delete();
    send_cmd(ACT_FORMAT, 9'd0, r);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      n = active_blocks();
      pick = $urandom_range(0, 99);
      if (pick < 2) act = ACT_FORMAT;
      else if (pick < 27) act = ACT_ALLOC;
      else if (pick < 57) act = ACT_EXTEND;
      else if (pick < 65) act = ACT_FREE_CHAIN;
      else if (pick < 75) act = ACT_FREE_BLOCK;
      else if (pick < 97) act = ACT_READ_LINK;
      else act = (pick[0]) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
      sel = $urandom_range(0, 99);
      if (sel < 55 && chain_heads.size() != 0)
        blk = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      else if (sel < 85)
        blk = 9'($urandom_range(0, n - 1));
      else
        blk = 9'($urandom_range(0, 511));
      send_cmd(act, blk, r);
      if (act == ACT_ALLOC && r.st == STAT_OK) begin
        chain_heads.push_back(r.blk);
        if (chain_heads.size() > MAX_HEADS) void'(chain_heads.pop_front());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  function automatic void check_field(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endfunction

  // Result side: compare each taken word with the oldest prediction, then pick
  // the next ready level from alternating random ready and stall runs (always ready when steady).
  always @(posedge clk) begin : reply_check
    link_reply_t want;
    if (rst_n) begin
      if (reply_valid && reply_ready) begin
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got %h", $time, reply_word);
        end else begin
          want = pending_replies.pop_front();
          check_field("result_block", want.blk, reply_word[8:0]);
          check_field("is_end", want.end_flag, reply_word[9]);
          check_field("status", int'(want.st), reply_word[11:10]);
          check_field("pad bits", 0, reply_word[15:12]);
        end
      end
      if (rx_steady) begin
        rx_stall = 1'b0;
      end else if (rx_run == 0) begin
        rx_stall = !rx_stall;
        rx_run = rx_stall ? $urandom_range(1, 5) : $urandom_range(1, 12);
      end else begin
        rx_run--;
      end
      reply_ready <= !rx_stall;
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** fat_chain_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_BLK; i++) link_copy[i] = LINK_FREE;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The clearing pass keeps tready low; the first handshake waits it out.
    test_reset_behavior();
    test_table_limits();
    test_random_traffic(10'h3FF, 10'd64, 1'b0, 1'b0);
    test_random_traffic(10'd2, 10'd1, 1'b0, 1'b1);
    test_random_traffic(10'd8, 10'd2, 1'b1, 1'b0);
    test_random_traffic(10'd500, 10'd4, 1'b0, 1'b0);
    test_random_traffic(10'd300, 10'd33, 1'b0, 1'b0);
    test_random_traffic(10'($urandom_range(2, 512)), 10'($urandom_range(1, 64)),
                        1'b0, 1'b0);
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** fat_chain_allocator: PASSED **");
    end else begin
      $display("** fat_chain_allocator: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fca_pkg.sv
rtl/fat_chain_allocator.sv
dv/fat_chain_allocator_test.sv
